FILE: hdl/tls_pkg.sv
// ----------------------------------------------------------------------------
// tls_pkg
// Shared types and constants for the timed launch sequencer: beat payloads,
// phase encoding, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package tls_pkg;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_RESET = 3'd1,
		PH_DOWN  = 3'd2,
		PH_CLOSE = 3'd3,
		PH_UP    = 3'd4,
		PH_OPEN  = 3'd5,
		PH_FIRE  = 3'd6,
		PH_DONE  = 3'd7
	} phase_t;

	// Trigger commands.
	localparam logic [1:0] TRIG_NONE  = 2'd0;
	localparam logic [1:0] TRIG_OPEN  = 2'd1;
	localparam logic [1:0] TRIG_CLOSE = 2'd2;

	// Slider move commands.
	localparam logic [1:0] MOVE_NONE = 2'd0;
	localparam logic [1:0] MOVE_DOWN = 2'd1;
	localparam logic [1:0] MOVE_UP   = 2'd2;

	// Slider status codes.
	localparam logic [1:0] SLIDER_IDLE = 2'd0;
	localparam logic [1:0] SLIDER_DOWN = 2'd1;
	localparam logic [1:0] SLIDER_UP   = 2'd2;

	// Remote switch positions.
	localparam logic [1:0] SW_START = 2'd1;
	localparam logic [1:0] SW_STOP  = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_RESET_HOLD = 2'd0;
	localparam logic [1:0] REG_CLOSE_HOLD = 2'd1;
	localparam logic [1:0] REG_OPEN_HOLD  = 2'd2;
	localparam logic [1:0] REG_FIRE_PULSE = 2'd3;

	localparam int unsigned TICK_W = 16;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam logic [TICK_W-1:0] RESET_HOLD_DEFAULT = 16'd300;
	localparam logic [TICK_W-1:0] CLOSE_HOLD_DEFAULT = 16'd350;
	localparam logic [TICK_W-1:0] OPEN_HOLD_DEFAULT  = 16'd250;
	localparam logic [TICK_W-1:0] FIRE_PULSE_DEFAULT = 16'd120;

	typedef struct packed {
		logic       link_online;
		logic [1:0] switch_position;
		logic [1:0] slider_status;
	} tls_in_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       gimbal_center;
		logic       gimbal_reset;
		logic       slider_rehome;
		logic [1:0] trigger_command;
		logic [1:0] slider_move;
		logic       motors_off;
	} tls_out_t;

	typedef struct packed {
		logic [TICK_W-1:0] reset_hold_ticks;
		logic [TICK_W-1:0] close_hold_ticks;
		logic [TICK_W-1:0] open_hold_ticks;
		logic [TICK_W-1:0] fire_pulse_ticks;
	} tls_cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [TICK_W-1:0] elapsed;
		logic [1:0]        last_switch;
	} tls_state_t;

endpackage

FILE: hdl/tls_step.sv
// ----------------------------------------------------------------------------
// tls_step
// One control tick of the launch sequence: from the current state, the tick
// beat and the hold registers, works out the next state and the commands.
// ----------------------------------------------------------------------------
module tls_step
	import tls_pkg::*;
(
	input  tls_state_t cur,
	input  tls_in_t    tick,
	input  tls_cfg_t   cfg,
	output tls_state_t nxt,
	output tls_out_t   cmd
);

	always_comb begin
		phase_t            ph;
		logic [TICK_W-1:0] el;
		logic [1:0]        last_sw;
		tls_out_t          o;

		o = '0;
		ph = cur.phase;
		last_sw = cur.last_switch;
		// The counter saturates rather than wrapping.
		el = (cur.elapsed == TICK_MAX) ? cur.elapsed : cur.elapsed + 1'b1;

		if (!tick.link_online) begin
			ph = PH_IDLE;
			el = '0;
			o.slider_rehome = 1'b1;
			o.trigger_command = TRIG_OPEN;
			o.gimbal_reset = 1'b1;
			o.motors_off = 1'b1;
		end else begin
			if (tick.switch_position == SW_START && last_sw != SW_START) begin
				ph = PH_RESET;
				el = '0;
			end else if (tick.switch_position == SW_STOP && last_sw != SW_STOP) begin
				ph = PH_IDLE;
				el = '0;
				o.slider_rehome = 1'b1;
				o.trigger_command = TRIG_OPEN;
				o.gimbal_reset = 1'b1;
			end
			last_sw = tick.switch_position;

			// A phase entered above acts within the same tick.
			unique case (ph)
				PH_RESET: begin
					o.gimbal_center = 1'b1;
					o.slider_rehome = 1'b1;
					o.trigger_command = TRIG_OPEN;
					if (el >= cfg.reset_hold_ticks) begin
						ph = PH_DOWN;
						el = '0;
					end
				end
				PH_DOWN: begin
					if (tick.slider_status == SLIDER_IDLE) begin
						o.slider_move = MOVE_DOWN;
					end
					if (tick.slider_status == SLIDER_DOWN) begin
						ph = PH_CLOSE;
						el = '0;
					end
				end
				PH_CLOSE: begin
					o.trigger_command = TRIG_CLOSE;
					if (el >= cfg.close_hold_ticks) begin
						o.slider_rehome = 1'b1;
						ph = PH_UP;
						el = '0;
					end
				end
				PH_UP: begin
					if (tick.slider_status == SLIDER_IDLE) begin
						o.slider_move = MOVE_UP;
					end
					if (tick.slider_status == SLIDER_UP) begin
						ph = PH_OPEN;
						el = '0;
					end
				end
				PH_OPEN: begin
					o.trigger_command = TRIG_OPEN;
					if (el >= cfg.open_hold_ticks) begin
						ph = PH_FIRE;
						el = '0;
					end
				end
				PH_FIRE: begin
					if (el < cfg.fire_pulse_ticks) begin
						o.trigger_command = TRIG_CLOSE;
					end else begin
						o.trigger_command = TRIG_OPEN;
						ph = PH_DONE;
						el = '0;
					end
				end
				PH_IDLE, PH_DONE: begin
				end
				default: begin
				end
			endcase
		end

		o.phase = ph;
		nxt.phase = ph;
		nxt.elapsed = el;
		nxt.last_switch = last_sw;
		cmd = o;
	end

endmodule

FILE: hdl/timed_launch_sequencer_core.sv
// ----------------------------------------------------------------------------
// timed_launch_sequencer_core
// Launch sequencer: one control tick per input beat, one command beat out.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   in        sink       in_valid / in_ready    in_data   (tls_in_t)
//   out       source     out_valid / out_ready  out_data  (tls_out_t)
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted tick beat is captured in the input register and, once the
// output register can take it, is evaluated against the sequencer state and
// written to the output register; one tick beat can be taken every cycle
// while out_ready holds. The output register is the only place that
// can stall; while it is full and not taken the input register holds its beat,
// and the input side is ready while the input register is empty or its beat
// moves on to the output register in that same cycle.
// Reset puts the sequence idle with a cleared tick counter, the last switch
// position at stop and the hold registers at their default values.
// Configuration writes are always taken and are registered.
// ----------------------------------------------------------------------------
module timed_launch_sequencer_core
	import tls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  tls_in_t     in_data,

	output logic        out_valid,
	input  logic        out_ready,
	output tls_out_t    out_data,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Input register stage.
	logic    valid_s1;
	tls_in_t data_s1;

	// Output register stage.
	logic     valid_s2;
	tls_out_t data_s2;

	// Sequencer state and hold registers.
	tls_state_t state_q;
	tls_cfg_t   cfg_q;

	tls_state_t state_nxt;
	tls_out_t   cmd;
	logic       advance;

	// The tick in the input register moves on whenever the output register is
	// empty or is being emptied in this same cycle; the state is updated at
	// that moment, so the next tick always sees the state this one left.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	assign cfg_ready = 1'b1;

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	tls_step u_step (
		.cur  (state_q),
		.tick (data_s1),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.cmd  (cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_IDLE;
			state_q.elapsed     <= '0;
			state_q.last_switch <= SW_STOP;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Hold registers, written by index; every index names a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_hold_ticks <= RESET_HOLD_DEFAULT;
			cfg_q.close_hold_ticks <= CLOSE_HOLD_DEFAULT;
			cfg_q.open_hold_ticks  <= OPEN_HOLD_DEFAULT;
			cfg_q.fire_pulse_ticks <= FIRE_PULSE_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESET_HOLD: cfg_q.reset_hold_ticks <= cfg_data;
				REG_CLOSE_HOLD: cfg_q.close_hold_ticks <= cfg_data;
				REG_OPEN_HOLD:  cfg_q.open_hold_ticks  <= cfg_data;
				REG_FIRE_PULSE: cfg_q.fire_pulse_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule
